>>> src/agc_db_pkg.sv
// ----------------------------------------------------------------------------
// agc_db_pkg: shared types and constants for the gated dB-domain AGC
// Holds the sequencer states, register indexes and the 2^(2^-k) table.
// ----------------------------------------------------------------------------
`default_nettype none

package agc_db_pkg;

  localparam int unsigned SampleBitsDefault = 24;
  localparam int unsigned HoldBitsDefault   = 24;

  // operand width of the shared multiplier
  localparam int unsigned MulW  = 33;
  // smoothed gain in Q.16 dB, wide enough for any goal
  localparam int unsigned GainW = 26;
  localparam int unsigned RomN  = 16;

  // log2(10)/20 in Q0.32
  localparam logic [31:0] Log2TenOver20 = 32'd713378626;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_GATE_OFS  = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_GATE_RET  = 3'd4,
    REG_HOLD      = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_SMOOTH,
    S_EXP,
    S_FRAC,
    S_MLOOP,
    S_MACC,
    S_SL,
    S_SR,
    S_RD,
    S_OUT
  } agc_state_e;

  typedef logic [31:0] exp_rom_t [RomN];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry k holds 2^(2^-(k+1)) in Q1.30
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t   t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    t[0] = r[31:0];
    for (int k = 1; k < RomN; k++) begin
      r = isqrt64(r << 30);
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

`default_nettype wire

>>> src/agc_db_mul.sv
// ----------------------------------------------------------------------------
// agc_db_mul: shared signed multiplier with registered product
// All products of the sequencer go through this one unit.
// ----------------------------------------------------------------------------
`default_nettype none

module agc_db_mul (
  input  wire logic                                  clk_i,
  input  wire logic signed [agc_db_pkg::MulW-1:0]    a_i,
  input  wire logic signed [agc_db_pkg::MulW-1:0]    b_i,
  output logic signed      [2*agc_db_pkg::MulW-1:0]  p_o
);
  import agc_db_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

>>> src/gated_db_agc_gain_smoother.sv
// ----------------------------------------------------------------------------
// gated_db_agc_gain_smoother: stereo AGC with level gate, working in dB
// Smooths a dB gain toward target minus level and scales a sample pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per stereo sample: two levels in Q7.8 dB and the
//   left/right samples. m_axis returns one beat per input beat with both
//   scaled samples and the applied gain in tdata, the gate flag in tuser.
//   cfg writes one of six registers per beat; it is always ready. the user
//   must write it only while the block is idle; the block does not enforce it.
// Timing:
//   one beat at a time through a single shared multiplier under a sequencer.
//   after an input beat the sequencer steps through S_GAIN, S_SMOOTH (only
//   when smoothing runs, skipped when the gain holds), S_EXP, S_FRAC, the
//   fraction loop of S_MLOOP with an S_MACC for each set bit of the 16-bit
//   octave fraction, then S_SL, S_SR and S_RD; tvalid rises in S_OUT. the
//   next beat is taken only once the result has left.
// Reset:
//   gain 0 dB, gate clear, hold counter zero, registers at their defaults.
// Stall:
//   a result waits in the output register while m_axis_tready_i is low; the
//   input side stays not ready until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_db_agc_gain_smoother #(
  parameter int unsigned SAMPLE_BITS     = agc_db_pkg::SampleBitsDefault,
  parameter int unsigned HOLD_COUNT_BITS = agc_db_pkg::HoldBitsDefault,
  localparam int unsigned InW  = ((32 + 2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((16 + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // level_left_db, level_right_db, sample_left, sample_right, zero pad
  input  wire logic [InW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // out_left, out_right, gain_db, zero pad
  output logic [OutW-1:0]      m_axis_tdata_o,
  // gate_active
  output logic                 m_axis_tuser_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import agc_db_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned HB = HOLD_COUNT_BITS;
  localparam int unsigned PW = 2 * MulW;
  localparam logic signed [PW-1:0] SMax = (PW'(1) <<< (SB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SMin = -(PW'(1) <<< (SB - 1));

  agc_state_e state_q, state_d;

  logic signed [15:0]    tgt_q, ofs_q;
  logic [31:0]           att_q, rel_q, ret_q;
  logic [23:0]           hold_q;
  logic signed [GainW-1:0] gain_q, gain_d;
  logic                  gate_q, gate_d;
  logic [HB-1:0]         cnt_q, cnt_d;
  logic signed [15:0]    ll_q, lr_q;
  logic signed [SB-1:0]  sl_q, sr_q;
  logic signed [GainW-1:0] goal_q, goal_d;
  logic                  neg_q, neg_d;
  logic signed [5:0]     n_q, n_d;
  logic [15:0]           f_q, f_d;
  logic [31:0]           m_q, m_d;
  logic [3:0]            k_q, k_d;
  logic signed [SB-1:0]  outl_q, outl_d, outr_q, outr_d;
  logic signed [15:0]    gdb_q, gdb_d;
  logic                  smooth_go;

  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]   prod;

  agc_db_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  function automatic logic signed [SB-1:0] round_sat(input logic signed [PW-1:0] p,
                                                    input logic [5:0] sh);
    logic signed [PW-1:0] v;
    v = (p + (PW'(1) <<< (sh - 6'd1))) >>> sh;
    if (v > SMax) begin
      v = SMax;
    end else if (v < SMin) begin
      v = SMin;
    end
    return v[SB-1:0];
  endfunction

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tdata_o  = OutW'({gdb_q, outr_q, outl_q});
  assign m_axis_tuser_o  = gate_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_axis_tvalid_i) state_d = S_GAIN;
      S_GAIN:   state_d = smooth_go ? S_SMOOTH : S_EXP;
      S_SMOOTH: state_d = S_EXP;
      S_EXP:    state_d = S_FRAC;
      S_FRAC:   state_d = S_MLOOP;
      S_MLOOP: begin
        if (f_q[15])          state_d = S_MACC;
        else if (k_q == 4'd15) state_d = S_SL;
      end
      S_MACC:   state_d = (k_q == 4'd15) ? S_SL : S_MLOOP;
      S_SL:     state_d = S_SR;
      S_SR:     state_d = S_RD;
      S_RD:     state_d = S_OUT;
      S_OUT:    if (m_axis_tready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and multiplier operands
  always_comb begin
    logic signed [15:0]     lvl;
    logic signed [16:0]     thr, diff;
    logic [HB-1:0]          cnt_new;
    logic [31:0]            coef;
    logic signed [GainW:0]  d;
    logic [GainW-1:0]       mag;
    logic [GainW-1:0]       p;
    logic signed [GainW:0]  gr;
    logic signed [GainW-8:0] gs;
    logic [5:0]             sh;

    gain_d = gain_q;
    gate_d = gate_q;
    cnt_d  = cnt_q;
    goal_d = goal_q;
    neg_d  = neg_q;
    n_d    = n_q;
    f_d    = f_q;
    m_d    = m_q;
    k_d    = k_q;
    outl_d = outl_q;
    outr_d = outr_q;
    gdb_d  = gdb_q;
    smooth_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;

    lvl     = (ll_q > lr_q) ? ll_q : lr_q;
    thr     = 17'(tgt_q) + 17'(ofs_q);
    diff    = 17'(tgt_q) - 17'(lvl);
    cnt_new = gate_q ? ((cnt_q == '1) ? cnt_q : cnt_q + HB'(1)) : '0;
    coef    = att_q;
    gr      = (GainW+1)'(gain_q) + (GainW+1)'(128);
    gs      = gr[GainW:8];
    sh      = 6'(7'sd30 - 7'(n_q));
    d       = '0;
    mag     = '0;
    p       = prod[GainW+31:32];

    case (state_q)
      S_GAIN: begin
        cnt_d = cnt_new;
        if (17'(lvl) > thr) begin
          gate_d = 1'b0;
          goal_d = GainW'($signed({diff, 8'd0}));
          if (goal_d < gain_q) begin
            coef = att_q;
            smooth_go = 1'b1;
          end else if (goal_d > gain_q) begin
            coef = rel_q;
            smooth_go = 1'b1;
          end
        end else begin
          gate_d = 1'b1;
          goal_d = '0;
          coef   = ret_q;
          smooth_go = (33'(cnt_new) > 33'(hold_q)) && (gain_q != '0);
        end
        d     = (GainW+1)'(gain_q) - (GainW+1)'(goal_d);
        neg_d = d[GainW];
        mag   = neg_d ? GainW'(-d) : GainW'(d);
        mul_a = MulW'(mag);
        mul_b = MulW'(coef);
      end
      S_SMOOTH: begin
        gain_d = neg_q ? goal_q - GainW'(p) : goal_q + GainW'(p);
      end
      S_EXP: begin
        if (gs > (GainW-7)'(32767)) begin
          gdb_d = 16'sd32767;
        end else if (gs < -(GainW-7)'(32768)) begin
          gdb_d = -16'sd32768;
        end else begin
          gdb_d = gs[15:0];
        end
        mul_a = MulW'(gdb_d);
        mul_b = MulW'(Log2TenOver20);
      end
      S_FRAC: begin
        // octaves in Q.16 after the floor shift by 24
        n_d = prod[45:40];
        f_d = prod[39:24];
        m_d = 32'd1 << 30;
        k_d = '0;
      end
      S_MLOOP: begin
        mul_a = MulW'(m_q);
        mul_b = MulW'(ExpRom[k_q]);
        if (!f_q[15]) begin
          f_d = f_q << 1;
          k_d = k_q + 4'd1;
        end
      end
      S_MACC: begin
        m_d = 32'((prod[61:0] + 62'(1 << 29)) >> 30);
        f_d = f_q << 1;
        k_d = k_q + 4'd1;
      end
      S_SL: begin
        mul_a = MulW'(sl_q);
        mul_b = MulW'(m_q);
      end
      S_SR: begin
        outl_d = round_sat(prod, sh);
        mul_a  = MulW'(sr_q);
        mul_b  = MulW'(m_q);
      end
      S_RD: begin
        outr_d = round_sat(prod, sh);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tgt_q   <= -16'sd6144;
      ofs_q   <= -16'sd5120;
      att_q   <= 32'd4294955978;
      rel_q   <= 32'd4294955978;
      ret_q   <= 32'd4294958749;
      hold_q  <= 24'd96000;
      gain_q  <= '0;
      gate_q  <= 1'b0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      gain_q  <= gain_d;
      gate_q  <= gate_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TARGET:   tgt_q  <= cfg_data_i[15:0];
          REG_GATE_OFS: ofs_q  <= cfg_data_i[15:0];
          REG_ATTACK:   att_q  <= cfg_data_i;
          REG_RELEASE:  rel_q  <= cfg_data_i;
          REG_GATE_RET: ret_q  <= cfg_data_i;
          REG_HOLD:     hold_q <= cfg_data_i[23:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ll_q <= s_axis_tdata_i[15:0];
      lr_q <= s_axis_tdata_i[31:16];
      sl_q <= s_axis_tdata_i[32 +: SB];
      sr_q <= s_axis_tdata_i[32 + SB +: SB];
    end
    goal_q <= goal_d;
    neg_q  <= neg_d;
    n_q    <= n_d;
    f_q    <= f_d;
    m_q    <= m_d;
    outl_q <= outl_d;
    outr_q <= outr_d;
    gdb_q  <= gdb_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while a result is pending");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_GAIN))
    else $error("accepted beat did not start the sequencer");

  a_macc_from_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MACC) |-> ($past(state_q) == S_MLOOP))
    else $error("fraction step taken out of order");

endmodule

`default_nettype wire

>>> tb/gated_db_agc_gain_smoother_tb.sv
// ----------------------------------------------------------------------------
// gated_db_agc_gain_smoother_tb: self-checking bench for the gated dB AGC
// Drives level/sample beats and register writes with random gaps and stalls,
// predicts every output beat with its own fixed-point AGC model, and checks
// each field of each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

class agc_scoreboard;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [15:0] gain;
    logic        gate;
  } agc_beat_t;

  localparam longint unsigned RunMax = (64'd1 << 24) - 1;

  agc_beat_t        pending_q[$];
  longint unsigned  gain_rom[16];
  int               errors;
  int               n_items;
  int               n_gated;
  int               n_glides;
  int               n_sat;

  // register copies
  longint           target_db;
  longint           gate_ofs_db;
  longint unsigned  att_c;
  longint unsigned  rel_c;
  longint unsigned  ret_c;
  longint unsigned  hold_n;

  // smoother state
  longint           gain_q16;
  bit               gated;
  longint unsigned  run_cnt;

  function new();
    gain_rom[0] = int_root(64'd1 << 61);
    for (int k = 1; k < 16; k++) begin
      gain_rom[k] = int_root(gain_rom[k-1] << 30);
    end
    target_db   = -6144;
    gate_ofs_db = -5120;
    att_c       = 64'd4294955978;
    rel_c       = 64'd4294955978;
    ret_c       = 64'd4294958749;
    hold_n      = 96000;
    gain_q16    = 0;
    gated       = 0;
    run_cnt     = 0;
    errors      = 0;
    n_items     = 0;
    n_gated     = 0;
    n_glides    = 0;
    n_sat       = 0;
  endfunction

  static function longint unsigned int_root(longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem  = v;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function void write_reg(agc_db_pkg::cfg_reg_e idx, logic [31:0] val);
    case (idx)
      agc_db_pkg::REG_TARGET:   target_db   = longint'($signed(val[15:0]));
      agc_db_pkg::REG_GATE_OFS: gate_ofs_db = longint'($signed(val[15:0]));
      agc_db_pkg::REG_ATTACK:   att_c       = val;
      agc_db_pkg::REG_RELEASE:  rel_c       = val;
      agc_db_pkg::REG_GATE_RET: ret_c       = val;
      agc_db_pkg::REG_HOLD:     hold_n      = val[23:0];
      default: ;
    endcase
  endfunction

  // one-pole step that always lands on the goal when c is zero
  function longint glide(longint from, longint goal, longint unsigned c);
    longint          d;
    longint unsigned mag;
    longint unsigned p;
    d   = from - goal;
    mag = (d < 0) ? -d : d;
    p   = (mag * c) >> 32;
    return (d < 0) ? goal - longint'(p) : goal + longint'(p);
  endfunction

  function logic [23:0] apply_gain(logic [23:0] raw, longint gdb);
    longint          s;
    longint          e;
    longint          n;
    longint          v;
    longint unsigned m;
    logic [15:0]     f;
    int              sh;
    s = longint'($signed(raw));
    e = (gdb * 64'sd713378626) >>> 24;
    n = e >>> 16;
    f = e[15:0];
    m = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      if (f[15-k]) m = (m * gain_rom[k] + (64'd1 << 29)) >> 30;
    end
    sh = 30 - n;
    v  = s * longint'(m) + (longint'(1) << (sh - 1));
    v  = v >>> sh;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function void note_input(logic [15:0] ll, logic [15:0] lr, logic [23:0] sl,
                           logic [23:0] sr);
    longint    lvl;
    longint    goal;
    longint    gq;
    agc_beat_t b;
    if (gated) begin
      if (run_cnt < RunMax) run_cnt++;
    end else begin
      run_cnt = 0;
    end
    lvl = longint'($signed(ll));
    if (longint'($signed(lr)) > lvl) lvl = longint'($signed(lr));
    if (lvl > target_db + gate_ofs_db) begin
      goal = (target_db - lvl) * 256;
      if (goal < gain_q16) gain_q16 = glide(gain_q16, goal, att_c);
      else if (goal > gain_q16) gain_q16 = glide(gain_q16, goal, rel_c);
      gated = 0;
    end else begin
      gated = 1;
      n_gated++;
      if (run_cnt > hold_n && gain_q16 != 0) begin
        gain_q16 = glide(gain_q16, 0, ret_c);
        n_glides++;
      end
    end
    gq = (gain_q16 + 128) >>> 8;
    if (gq > 32767 || gq < -32768) n_sat++;
    if (gq > 32767) gq = 32767;
    if (gq < -32768) gq = -32768;
    b.left  = apply_gain(sl, gq);
    b.right = apply_gain(sr, gq);
    b.gain  = gq[15:0];
    b.gate  = gated;
    pending_q.insert(pending_q.size(), b);
    n_items++;
  endfunction

  function void check_result(logic [63:0] data, logic user);
    agc_beat_t b;
    if (pending_q.size() == 0) begin
      $error("output beat with nothing expected: data %h gate %b", data, user);
      errors++;
      return;
    end
    b = pending_q.pop_front();
    if (data[23:0] !== b.left) begin
      $error("out_left: expected %h, got %h", b.left, data[23:0]);
      errors++;
    end
    if (data[47:24] !== b.right) begin
      $error("out_right: expected %h, got %h", b.right, data[47:24]);
      errors++;
    end
    if (data[63:48] !== b.gain) begin
      $error("gain_db: expected %h, got %h", b.gain, data[63:48]);
      errors++;
    end
    if (user !== b.gate) begin
      $error("gate_active: expected %b, got %b", b.gate, user);
      errors++;
    end
  endfunction

endclass

module gated_db_agc_gain_smoother_tb;
  import agc_db_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int          ItemsPerPhase = 104;
  // indexes past the register list, writes there must be ignored
  localparam logic [2:0]  RegSpareA = 3'd6;
  localparam logic [2:0]  RegSpareB = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  agc_scoreboard gain_check;
  int unsigned   cycles;
  bit            tx_gaps;
  bit            rx_stalls;
  bit            rx_hold_req;

  gated_db_agc_gain_smoother u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      gain_check.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // receiver back-pressure, with one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        stall = 400;
      end
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        stall--;
      end else if (!rx_stalls || $urandom_range(0, 99) < 75) begin
        m_axis_tready_i = 1'b1;
      end else begin
        m_axis_tready_i = 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end
    end
  end

  task automatic tx_gap();
    int g;
    if (!tx_gaps) return;
    g = $urandom_range(0, 99);
    if (g < 65) return;
    if (g < 95) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(10, 60)) @(negedge clk_i);
  endtask

  task automatic send_beat(logic [15:0] ll, logic [15:0] lr, logic [23:0] sl,
                           logic [23:0] sr);
    tx_gap();
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {sr, sl, lr, ll};
    do @(posedge clk_i); while (!s_axis_tready_o);
    gain_check.note_input(ll, lr, sl, sr);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain();
    while (gain_check.pending_q.size() != 0) @(negedge clk_i);
    // result count equals item count, so this only covers the tail of the pipe
    repeat (45) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_check.write_reg(cfg_reg_e'(idx), val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      3: return 24'hffffff;
      4: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h80000000;
      3: return 32'hffffffff - $urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_db();
    case ($urandom_range(0, 5))
      0: return 32'hffff8000;
      1: return 32'h00007fff;
      2: return 32'($signed(16'($urandom)));
      default: return 32'(-longint'($urandom_range(0, 12000)));
    endcase
  endfunction

  task automatic random_phase(bit pressure);
    logic [15:0] lvl;
    logic [15:0] other;
    logic [15:0] prev;
    longint      thr;
    bit          loud;
    int          run;
    write_reg(REG_TARGET, pick_db());
    write_reg(REG_GATE_OFS, pick_db());
    write_reg(REG_ATTACK, pick_coeff());
    write_reg(REG_RELEASE, pick_coeff());
    write_reg(REG_GATE_RET, pick_coeff());
    case ($urandom_range(0, 3))
      0: write_reg(REG_HOLD, 32'h00ffffff);
      1: write_reg(REG_HOLD, 32'h0);
      default: write_reg(REG_HOLD, $urandom_range(1, 20));
    endcase
    if ($urandom_range(0, 1)) write_reg(RegSpareA, $urandom);
    if ($urandom_range(0, 1)) write_reg(RegSpareB, $urandom);
    tx_gaps   = $urandom_range(0, 3) != 0;
    rx_stalls = $urandom_range(0, 3) != 0;
    thr  = gain_check.target_db + gain_check.gate_ofs_db;
    run  = 0;
    loud = 1;
    prev = clamp16(thr + 1);
    for (int i = 0; i < ItemsPerPhase; i++) begin
      if (pressure && i == ItemsPerPhase / 2) rx_hold_req = 1;
      if (run == 0) begin
        run  = $urandom_range(1, 30);
        loud = $urandom_range(0, 1);
      end
      run--;
      if ($urandom_range(0, 11) == 0) begin
        lvl   = 16'($urandom);
        other = 16'($urandom);
      end else begin
        if (loud && $urandom_range(0, 1)) lvl = prev;
        else if (loud) lvl = clamp16(thr + 1 + $urandom_range(0, 3000));
        else lvl = clamp16(thr - $urandom_range(0, 3000));
        prev  = lvl;
        other = $urandom_range(0, 4) == 0 ? lvl
              : clamp16(longint'($signed(lvl)) - $urandom_range(0, 2000));
        if ($urandom_range(0, 1)) begin
          {lvl, other} = {other, lvl};
        end
      end
      send_beat(lvl, other, pick_sample(), pick_sample());
    end
    drain();
  endtask

  initial begin
    gain_check      = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_TARGET;
    cfg_data_i      = '0;
    tx_gaps         = 1;
    rx_stalls       = 1;
    rx_hold_req     = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // defaults: gate sits at -44 dB
    send_beat(16'hd400, 16'hd400, 24'h7fffff, 24'h800000);  // level on the gate
    send_beat(16'hd401, 16'h8000, 24'h7fffff, 24'h800000);
    send_beat(16'h7fff, 16'h8000, 24'h7fffff, 24'h800000);
    send_beat(16'h8000, 16'h7fff, 24'h800000, 24'h7fffff);
    send_beat(16'h8000, 16'h8000, 24'h000000, 24'hffffff);
    send_beat(16'h0000, 16'hffff, 24'h000001, 24'h555555);
    send_beat(16'h5555, 16'haaaa, 24'haaaaaa, 24'h555555);
    drain();

    // zero coefficients: jumps, equal goal, negative saturation, glide back
    write_reg(REG_TARGET, 32'hffff8000);
    write_reg(REG_GATE_OFS, 32'h0);
    write_reg(REG_ATTACK, 32'h0);
    write_reg(REG_RELEASE, 32'h0);
    write_reg(REG_GATE_RET, 32'h0);
    write_reg(REG_HOLD, 32'h0);
    send_beat(16'h7fff, 16'h0000, 24'h7fffff, 24'h800000);
    send_beat(16'h7fff, 16'h7fff, 24'h400000, 24'hc00000);
    send_beat(16'h8000, 16'h8000, 24'h7fffff, 24'h800000);
    send_beat(16'h8000, 16'h8000, 24'h7fffff, 24'h800000);
    send_beat(16'h0100, 16'h8000, 24'h123456, 24'hedcba9);
    send_beat(16'h0080, 16'h0080, 24'h123456, 24'hedcba9);
    drain();
    write_reg(REG_TARGET, 32'h00007fff);
    write_reg(REG_GATE_OFS, 32'hffff8000);
    write_reg(REG_RELEASE, 32'hffffffff);
    write_reg(REG_GATE_RET, 32'hffffffff);
    write_reg(REG_HOLD, 32'h00ffffff);
    send_beat(16'h0000, 16'h0000, 24'h7fffff, 24'h800000);
    send_beat(16'hffff, 16'hffff, 24'h7fffff, 24'h800000);
    send_beat(16'h8000, 16'hffff, 24'h000001, 24'hffffff);
    send_beat(16'h7fff, 16'h8000, 24'h7fffff, 24'h800000);
    drain();

    for (int p = 0; p < 8; p++) begin
      random_phase(p == 3);
    end

    $display("checked %0d beats: %0d gated, %0d glide steps, %0d clipped gains",
             gain_check.n_items, gain_check.n_gated, gain_check.n_glides,
             gain_check.n_sat);
    $display("covered 10 register settings incl. zero/full coefficients and hold extremes");
    if (gain_check.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/agc_db_pkg.sv
src/agc_db_mul.sv
src/gated_db_agc_gain_smoother.sv
tb/gated_db_agc_gain_smoother_tb.sv
